FILE: rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes for the seat reservation table
// Beat structs, entry word layout, command and status codes, and the
// controller state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  // Default table depth
  localparam int TABLE_DEPTH_DEF = 64;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 16;
  localparam int SEATS_W  = 16;
  localparam int TAG_W    = 27;
  localparam int SLOT_W   = 6;
  localparam int STAT_W   = 3;
  localparam int REFUSE_W = 20;

  localparam logic [REFUSE_W-1:0] REFUSED_MAX = {REFUSE_W{1'b1}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SORT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_LOADED     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_SORTED     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_GRANTED    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_REFUSED    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_REPORT     = 3'd5;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 3'd6;

  // Input beat
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [KEY_W-1:0]   key_code;
    logic [SEATS_W-1:0] seat_count;
    logic [TAG_W-1:0]   requester_id;
    logic [SLOT_W-1:0]  slot_index;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [TAG_W-1:0]    requester_tag;
    logic [KEY_W-1:0]    out_key;
    logic [SEATS_W-1:0]  out_seats;
    logic [REFUSE_W-1:0] out_refused;
    logic [SLOT_W-1:0]   out_slot;
  } out_beat_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SEATS_W-1:0]  capacity;
    logic [REFUSE_W-1:0] refused;
  } entry_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_REQ_CHK,
    S_SORT_RD0,
    S_SORT_LD0,
    S_SORT_CMP,
    S_SORT_WB,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/srt_store.sv
// ----------------------------------------------------------------------------
// srt_store: entry memory of the seat reservation table
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_store #(
  parameter int DEPTH = srt_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire srt_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output srt_pkg::entry_t      rdata
);

  srt_pkg::entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srt_engine.sv
// ----------------------------------------------------------------------------
// srt_engine: command sequencer for the seat reservation table
// Runs load, sort, request and read commands against the entry memory, with
// request and sort by read-modify-write, and hands one result beat to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_engine #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // command side
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire srt_pkg::in_beat_t in_beat,
  // result side
  output logic                   res_valid,
  input  wire logic              res_taken,
  output srt_pkg::out_beat_t     res
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam int REFW = srt_pkg::REFUSE_W;

  srt_pkg::state_t state, state_next;

  // Registers
  srt_pkg::in_beat_t  beat;
  srt_pkg::out_beat_t res_next;
  logic               res_load;
  logic [CW-1:0]      count;
  logic               count_inc;
  logic [CW-1:0]      lo, hi1;
  logic [IW-1:0]      mid_q;
  srt_pkg::entry_t    cur;
  logic [IW-1:0]      j;
  logic [IW-1:0]      last;
  logic               moved;

  // Memory port
  logic               mem_we, mem_re;
  logic [IW-1:0]      mem_waddr, mem_raddr;
  srt_pkg::entry_t    mem_wdata, mem_rdata;

  // Search probe: bounds to try now and the midpoint they give
  logic [CW-1:0]      srch_lo, srch_hi;
  logic [CW:0]        span_sum;
  logic [IW-1:0]      srch_mid;
  logic               probe_go;

  // Compare results and derived values
  logic               key_eq, key_lt, grant, do_swap;
  logic [REFW:0]      refused_sum;
  logic [srt_pkg::REFUSE_W-1:0] refused_sat;
  logic               table_full, slot_ok;
  logic [IW-1:0]      last_dec;
  logic               take;

  srt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign take = in_valid && !in_stall;

  // Shared compare and arithmetic
  always_comb begin
    key_eq      = (mem_rdata.key == beat.key_code);
    key_lt      = (beat.key_code < mem_rdata.key);
    grant       = (mem_rdata.capacity >= beat.seat_count);
    do_swap     = (cur.key > mem_rdata.key);
    refused_sum = (REFW + 1)'(mem_rdata.refused) + (REFW + 1)'(beat.seat_count);
    refused_sat = refused_sum[REFW] ? srt_pkg::REFUSED_MAX : refused_sum[REFW-1:0];
    table_full  = (count >= DEPTH_C);
    slot_ok     = (32'(beat.slot_index) < 32'(count));
    last_dec    = last - IW'(1);
  end

  // Search bounds: fresh range on a new request, narrowed range after a miss
  always_comb begin
    if (state == srt_pkg::S_REQ_CHK) begin
      srch_lo = key_lt ? lo : (CW'(mid_q) + CW'(1));
      srch_hi = key_lt ? CW'(mid_q) : hi1;
    end else begin
      srch_lo = '0;
      srch_hi = count;
    end
    span_sum = (CW + 1)'(srch_lo) + (CW + 1)'(srch_hi) - (CW + 1)'(1);
    srch_mid = IW'(span_sum >> 1);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      srt_pkg::S_IDLE: begin
        if (take) state_next = srt_pkg::S_EXEC;
      end
      srt_pkg::S_EXEC: begin
        unique case (beat.command)
          srt_pkg::CMD_LOAD:    state_next = srt_pkg::S_EMIT;
          srt_pkg::CMD_SORT:    state_next = (count < CW'(2)) ? srt_pkg::S_EMIT
                                                              : srt_pkg::S_SORT_RD0;
          srt_pkg::CMD_REQUEST: state_next = (srch_lo < srch_hi) ? srt_pkg::S_REQ_CHK
                                                                 : srt_pkg::S_EMIT;
          srt_pkg::CMD_READ:    state_next = slot_ok ? srt_pkg::S_RD_WAIT
                                                     : srt_pkg::S_EMIT;
          default:              state_next = srt_pkg::S_EMIT;
        endcase
      end
      srt_pkg::S_RD_WAIT: state_next = srt_pkg::S_EMIT;
      srt_pkg::S_REQ_CHK: begin
        if (key_eq || !(srch_lo < srch_hi)) state_next = srt_pkg::S_EMIT;
      end
      srt_pkg::S_SORT_RD0: state_next = srt_pkg::S_SORT_LD0;
      srt_pkg::S_SORT_LD0: state_next = srt_pkg::S_SORT_CMP;
      srt_pkg::S_SORT_CMP: begin
        if (j + IW'(1) == last) state_next = srt_pkg::S_SORT_WB;
      end
      srt_pkg::S_SORT_WB: begin
        state_next = (moved && last_dec != '0) ? srt_pkg::S_SORT_RD0 : srt_pkg::S_EMIT;
      end
      srt_pkg::S_EMIT: begin
        if (res_taken) state_next = srt_pkg::S_IDLE;
      end
      default: state_next = srt_pkg::S_IDLE;
    endcase
  end

  // Outputs: memory control, result beat, handshake
  always_comb begin
    in_stall  = 1'b1;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    res_load  = 1'b0;
    count_inc = 1'b0;
    probe_go  = 1'b0;
    res_next  = '0;
    res_next.requester_tag = beat.requester_id;

    unique case (state)
      srt_pkg::S_IDLE: in_stall = 1'b0;

      srt_pkg::S_EXEC: begin
        unique case (beat.command)
          // append an entry, or report a full table
          srt_pkg::CMD_LOAD: begin
            res_load       = 1'b1;
            res_next.out_key = beat.key_code;
            if (table_full) begin
              res_next.status = srt_pkg::STAT_TABLE_FULL;
            end else begin
              mem_we             = 1'b1;
              mem_waddr          = IW'(count);
              mem_wdata.key      = beat.key_code;
              mem_wdata.capacity = beat.seat_count;
              mem_wdata.refused  = '0;
              count_inc          = 1'b1;
              res_next.status    = srt_pkg::STAT_LOADED;
              res_next.out_seats = beat.seat_count;
              res_next.out_slot  = srt_pkg::SLOT_W'(count);
            end
          end
          // report at once if too short to sort, else start the sort passes
          srt_pkg::CMD_SORT: begin
            res_next.status = srt_pkg::STAT_SORTED;
            res_load        = (count < CW'(2));
          end
          // first probe of the search, or not found on an empty table
          srt_pkg::CMD_REQUEST: begin
            if (srch_lo < srch_hi) begin
              probe_go  = 1'b1;
              mem_re    = 1'b1;
              mem_raddr = srch_mid;
            end else begin
              res_load         = 1'b1;
              res_next.status  = srt_pkg::STAT_NOT_FOUND;
              res_next.out_key = beat.key_code;
            end
          end
          srt_pkg::CMD_READ: begin
            if (slot_ok) begin
              mem_re    = 1'b1;
              mem_raddr = IW'(beat.slot_index);
            end else begin
              res_load          = 1'b1;
              res_next.status   = srt_pkg::STAT_NOT_FOUND;
              res_next.out_slot = beat.slot_index;
            end
          end
          default: ;
        endcase
      end

      // entry report from memory
      srt_pkg::S_RD_WAIT: begin
        res_load             = 1'b1;
        res_next.status      = srt_pkg::STAT_REPORT;
        res_next.out_key     = mem_rdata.key;
        res_next.out_seats   = mem_rdata.capacity;
        res_next.out_refused = mem_rdata.refused;
        res_next.out_slot    = beat.slot_index;
      end

      // search step: hit updates the entry, miss narrows and probes again or reports not found
      srt_pkg::S_REQ_CHK: begin
        if (key_eq) begin
          res_load          = 1'b1;
          mem_we            = 1'b1;
          mem_waddr         = mid_q;
          res_next.out_key  = beat.key_code;
          res_next.out_slot = srt_pkg::SLOT_W'(mid_q);
          if (grant) begin
            mem_wdata.capacity   = mem_rdata.capacity - beat.seat_count;
            res_next.status      = srt_pkg::STAT_GRANTED;
            res_next.out_seats   = beat.seat_count;
            res_next.out_refused = mem_rdata.refused;
          end else begin
            mem_wdata.refused    = refused_sat;
            res_next.status      = srt_pkg::STAT_REFUSED;
            res_next.out_seats   = mem_rdata.capacity;
            res_next.out_refused = refused_sat;
          end
        end else if (srch_lo < srch_hi) begin
          probe_go  = 1'b1;
          mem_re    = 1'b1;
          mem_raddr = srch_mid;
        end else begin
          res_load         = 1'b1;
          res_next.status  = srt_pkg::STAT_NOT_FOUND;
          res_next.out_key = beat.key_code;
        end
      end

      srt_pkg::S_SORT_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end

      srt_pkg::S_SORT_LD0: begin
        mem_re    = 1'b1;
        mem_raddr = j + IW'(1);
      end

      // keep the smaller at j, carry the larger; prefetch j+2
      srt_pkg::S_SORT_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j;
        mem_wdata = do_swap ? mem_rdata : cur;
        if (j + IW'(1) != last) begin
          mem_re    = 1'b1;
          mem_raddr = j + IW'(2);
        end
      end

      // park the carried entry at the end of the pass
      srt_pkg::S_SORT_WB: begin
        mem_we          = 1'b1;
        mem_waddr       = last;
        mem_wdata       = cur;
        res_next.status = srt_pkg::STAT_SORTED;
        res_load        = !(moved && last_dec != '0);
      end

      srt_pkg::S_EMIT: res_valid = 1'b1;

      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srt_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (count_inc) count <= count + CW'(1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (take) beat <= in_beat;
    if (res_load) res <= res_next;
    if (probe_go) begin
      lo    <= srch_lo;
      hi1   <= srch_hi;
      mid_q <= srch_mid;
    end
    unique case (state)
      srt_pkg::S_EXEC:     last <= IW'(count - CW'(1));
      srt_pkg::S_SORT_RD0: begin
        j     <= '0;
        moved <= 1'b0;
      end
      srt_pkg::S_SORT_LD0: cur <= mem_rdata;
      srt_pkg::S_SORT_CMP: begin
        cur   <= do_swap ? cur : mem_rdata;
        moved <= moved | do_swap;
        j     <= j + IW'(1);
      end
      srt_pkg::S_SORT_WB:  last <= last_dec;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/seat_reservation_table_unit.sv
// ----------------------------------------------------------------------------
// seat_reservation_table_unit: keyed seat capacity table
// Loads (key, capacity) entries, sorts them by key, serves reservation
// requests by binary search and reports entries by slot.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------
//   req     | in        | req_valid/req_stall | srt_pkg::in_beat_t
//   rsp     | out       | rsp_valid/rsp_stall | srt_pkg::out_beat_t
//
// One command is in work at a time. Load writes one entry; read fetches
// one slot; request probes until a hit or an empty search range. Sort
// passes read slots 0 and 1, compare each pair, write back the carried entry,
// and repeat until no swap; all via the entry memory's single read port. The
// next beat is taken in the cycle after the result moves to the output
// register; a stalled one holds the result in the sequencer and stalls input.
// Reset clears the entry count; memory contents need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module seat_reservation_table_unit #(
  parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire srt_pkg::in_beat_t  req,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output srt_pkg::out_beat_t      rsp
);

  logic               res_valid;
  logic               res_taken;
  srt_pkg::out_beat_t res;

  srt_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .in_beat   (req),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .res       (res)
  );

  // Output register: takes a result when empty or being drained
  assign res_taken = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_taken) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) rsp <= res;
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the seat reservation table
// Sends load, sort, request and read commands over the req channel, predicts
// every response from a local copy of the table and checks each response
// beat field by field. Both channels see random idle and stall cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1130;
  // Longest quiet stretch: a sort of a full, reversed table plus stalls,
  // with a margin of several times that.
  localparam int IDLE_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [TAG_W-1:0] TAG_MAX = 27'd99999999;
  localparam logic [KEY_W-1:0] HOT_KEY = 16'hFFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_beat_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_beat_t rsp;

  // Local copy of the table
  entry_t seat_tbl [TABLE_DEPTH];
  int loaded = 0;

  out_beat_t booking_replies[$];
  int mismatch_count = 0;
  int random_sent = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  seat_reservation_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  // Table behavior: applies one command and returns its response beat
  function automatic out_beat_t table_response(input in_beat_t b);
    out_beat_t r;
    entry_t tmp;
    int lo;
    int hi;
    int mid;
    int hit;
    int pass;
    bit moved;
    logic [REFUSE_W:0] total;
    r = '0;
    r.requester_tag = b.requester_id;
    case (b.command)
      CMD_LOAD: begin
        r.out_key = b.key_code;
        if (loaded >= TABLE_DEPTH) begin
          r.status = STAT_TABLE_FULL;
        end else begin
          seat_tbl[loaded] = '{b.key_code, b.seat_count, '0};
          r.status = STAT_LOADED;
          r.out_seats = b.seat_count;
          r.out_slot = SLOT_W'(loaded);
          loaded++;
        end
      end
      CMD_SORT: begin
        // bubble sort, stops after a pass without a swap
        r.status = STAT_SORTED;
        if (loaded >= 2) begin
          pass = 0;
          do begin
            moved = 1'b0;
            for (int j = 0; j < loaded - 1 - pass; j++) begin
              if (seat_tbl[j].key > seat_tbl[j+1].key) begin
                tmp = seat_tbl[j];
                seat_tbl[j] = seat_tbl[j+1];
                seat_tbl[j+1] = tmp;
                moved = 1'b1;
              end
            end
            pass++;
          end while (pass < loaded && moved);
        end
      end
      CMD_REQUEST: begin
        // binary search over loaded entries only
        lo = 0;
        hi = loaded - 1;
        hit = -1;
        while (lo <= hi && hit < 0) begin
          mid = (lo + hi) / 2;
          if (seat_tbl[mid].key == b.key_code) hit = mid;
          else if (b.key_code < seat_tbl[mid].key) hi = mid - 1;
          else lo = mid + 1;
        end
        r.out_key = b.key_code;
        if (hit < 0) begin
          r.status = STAT_NOT_FOUND;
        end else if (seat_tbl[hit].capacity >= b.seat_count) begin
          seat_tbl[hit].capacity = seat_tbl[hit].capacity - b.seat_count;
          r.status = STAT_GRANTED;
          r.out_seats = b.seat_count;
          r.out_refused = seat_tbl[hit].refused;
          r.out_slot = SLOT_W'(hit);
        end else begin
          total = {1'b0, seat_tbl[hit].refused} + b.seat_count;
          if (total > REFUSED_MAX) total = REFUSED_MAX;
          seat_tbl[hit].refused = total[REFUSE_W-1:0];
          r.status = STAT_REFUSED;
          r.out_seats = seat_tbl[hit].capacity;
          r.out_refused = seat_tbl[hit].refused;
          r.out_slot = SLOT_W'(hit);
        end
      end
      default: begin
        r.out_slot = b.slot_index;
        if (b.slot_index < loaded) begin
          r.status = STAT_REPORT;
          r.out_key = seat_tbl[b.slot_index].key;
          r.out_seats = seat_tbl[b.slot_index].capacity;
          r.out_refused = seat_tbl[b.slot_index].refused;
        end else begin
          r.status = STAT_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_beat_t make_beat(input logic [CMD_W-1:0] cmd,
                                         input logic [KEY_W-1:0] key,
                                         input logic [SEATS_W-1:0] seats,
                                         input logic [TAG_W-1:0] tag,
                                         input logic [SLOT_W-1:0] slot);
    in_beat_t b;
    b.command = cmd;
    b.key_code = key;
    b.seat_count = seats;
    b.requester_id = tag;
    b.slot_index = slot;
    return b;
  endfunction

  // Random command; request keys mostly hit loaded entries
  function automatic in_beat_t random_command(input int load_pct, input int sort_pct,
                                              input int request_pct);
    in_beat_t b;
    int roll;
    int pick;
    b = make_beat(CMD_READ, KEY_W'($urandom), SEATS_W'($urandom),
                  TAG_W'($urandom_range(0, 99999999)), SLOT_W'($urandom));
    roll = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    if (roll < load_pct) begin
      b.command = CMD_LOAD;
      if (pick < 2 && loaded > 0) b.key_code = seat_tbl[$urandom_range(0, loaded - 1)].key;
      else if (pick == 2) b.key_code = $urandom_range(0, 1) ? '1 : '0;
      if ($urandom_range(0, 1)) b.seat_count = SEATS_W'($urandom_range(0, 2000));
    end else if (roll < load_pct + sort_pct) begin
      b.command = CMD_SORT;
    end else if (roll < load_pct + sort_pct + request_pct) begin
      b.command = CMD_REQUEST;
      if (pick == 9) begin
        // hammer one entry with big asks to drive its refused total to the cap
        b.key_code = HOT_KEY;
        b.seat_count = '1;
      end else begin
        if (pick < 8 && loaded > 0) b.key_code = seat_tbl[$urandom_range(0, loaded - 1)].key;
        case ($urandom_range(0, 3))
          0: b.seat_count = SEATS_W'($urandom_range(0, 15));
          1: b.seat_count = SEATS_W'($urandom_range(0, 500));
          2: b.seat_count = SEATS_W'($urandom_range(0, 4000));
          default: ;
        endcase
      end
    end
    return b;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Send one command beat, then log its expected response
  task automatic send_command(input in_beat_t b);
    int gap;
    if ($urandom_range(0, 31) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= b;
    do @(posedge clk); while (req_stall);
    booking_replies.push_back(table_response(b));
  endtask

  // Response check and output stall generation
  always @(posedge clk) begin
    out_beat_t want;
    int w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (booking_replies.size() == 0) begin
        report_mismatch($sformatf("response beat with nothing pending, status %0d",
                                  rsp.status));
      end else begin
        want = booking_replies.pop_front();
        check_field("status", rsp.status, want.status);
        check_field("requester_tag", rsp.requester_tag, want.requester_tag);
        check_field("out_key", rsp.out_key, want.out_key);
        check_field("out_seats", rsp.out_seats, want.out_seats);
        check_field("out_refused", rsp.out_refused, want.out_refused);
        check_field("out_slot", rsp.out_slot, want.out_slot);
      end
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      w = rx_quiet ? 0 : $urandom_range(0, 10);
      rsp_stall <= (w != 0);
      stall_left <= w;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= (stall_left > 1);
    end
  end

  // Watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Empty table: sort of nothing, a lookup and reads that find nothing
  task automatic test_empty_table();
    send_command(make_beat(CMD_SORT, '0, '0, '0, '0));
    send_command(make_beat(CMD_REQUEST, 16'h1234, 16'd10, 27'd17, '0));
    send_command(make_beat(CMD_READ, '0, '0, 27'd1, '0));
    send_command(make_beat(CMD_READ, '1, '1, TAG_MAX, '1));
  endtask

  // Field extremes, duplicate keys, unsorted search, grant and refuse
  task automatic test_load_and_lookup();
    send_command(make_beat(CMD_LOAD, '0, '0, '0, '0));
    send_command(make_beat(CMD_SORT, '0, '0, 27'd2, '0));
    send_command(make_beat(CMD_REQUEST, '0, '0, 27'd3, '0));
    send_command(make_beat(CMD_LOAD, '1, '1, TAG_MAX, '1));
    send_command(make_beat(CMD_LOAD, 16'h0100, 16'd100, 27'd4, '0));
    send_command(make_beat(CMD_LOAD, 16'h0100, 16'd7, 27'd5, '0));
    send_command(make_beat(CMD_LOAD, 16'h8000, 16'd50, 27'd6, '0));
    // search on a table that is not in order
    send_command(make_beat(CMD_REQUEST, 16'h8000, 16'd1, 27'd7, '0));
    send_command(make_beat(CMD_REQUEST, 16'h0100, 16'd1, 27'd8, '0));
    send_command(make_beat(CMD_SORT, '0, '0, 27'd9, '0));
    send_command(make_beat(CMD_REQUEST, '1, '1, TAG_MAX, '0));
    send_command(make_beat(CMD_REQUEST, '1, 16'd1, 27'd10, '0));
    send_command(make_beat(CMD_REQUEST, 16'h0100, 16'd101, 27'd11, '0));
    send_command(make_beat(CMD_REQUEST, 16'h4321, 16'd5, 27'd12, '0));
    send_command(make_beat(CMD_READ, '0, '0, 27'd13, 6'd1));
    send_command(make_beat(CMD_READ, '0, '0, 27'd14, 6'd4));
    send_command(make_beat(CMD_READ, '0, '0, 27'd15, 6'd5));
  endtask

  // Random mix while the table fills up
  task automatic test_random_fill();
    while (loaded < TABLE_DEPTH) begin
      send_command(random_command(40, 8, 30));
      random_sent++;
    end
  endtask

  // Random traffic on a full table: mostly requests and reads
  task automatic test_random_traffic();
    while (random_sent < RANDOM_ITEMS) begin
      send_command(random_command(8, 4, 60));
      random_sent++;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_load_and_lookup();
    test_random_fill();
    test_random_traffic();
    req_valid <= 1'b0;
    while (booking_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
